FILE: hw/rtl/isd_pkg.sv
package isd_pkg;

  localparam int AxisW   = 16;
  localparam int TimeW   = 32;
  localparam int MagW    = 16;
  localparam int CfgW    = 16;
  localparam int ShareW  = 17;
  localparam int ScoreW  = 17;
  localparam int HistW   = 9;
  localparam int DataW   = 32;
  localparam int AddrW   = 5;
  localparam int DefHistoryDepth = 256;

  localparam logic [ShareW-1:0] FullShare = 17'h10000;

  localparam logic [CfgW-1:0]   RstGyroLimit  = 16'd100;
  localparam logic [CfgW-1:0]   RstAccelLimit = 16'd100;
  localparam logic [CfgW-1:0]   RstHoldTime   = 16'd500;
  localparam logic [CfgW-1:0]   RstWindow     = 16'd1000;
  localparam logic [ShareW-1:0] RstGyroShare  = 17'd32768;

  typedef enum logic [2:0] {
    RegGyroLimit     = 3'd0,
    RegAccelDevLimit = 3'd1,
    RegHoldTime      = 3'd2,
    RegWindow        = 3'd3,
    RegGyroShare     = 3'd4
  } reg_idx_e;

endpackage

FILE: hw/rtl/isd_if.sv
interface isd_sample_if import isd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AxisW-1:0] rot_x;
  logic signed [AxisW-1:0] rot_y;
  logic signed [AxisW-1:0] rot_z;
  logic signed [AxisW-1:0] acc_x;
  logic signed [AxisW-1:0] acc_y;
  logic signed [AxisW-1:0] acc_z;
  logic [TimeW-1:0]        time_ms;

  modport source (output valid, rot_x, rot_y, rot_z, acc_x, acc_y, acc_z, time_ms,
                  input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, acc_x, acc_y, acc_z, time_ms,
                output ready);
endinterface

interface isd_result_if import isd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MagW-1:0]   rot_magnitude;
  logic [MagW-1:0]   acc_deviation;
  logic [ScoreW-1:0] score;
  logic [HistW-1:0]  history_count;
  logic [TimeW-1:0]  held_ms;
  logic              still;

  modport source (output valid, rot_magnitude, acc_deviation, score, history_count,
                  held_ms, still, input ready);
  modport sink (input valid, rot_magnitude, acc_deviation, score, history_count,
                held_ms, still, output ready);
endinterface

FILE: hw/rtl/isd_ram.sv
module isd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hw/rtl/isd_sqrt.sv
module isd_sqrt import isd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     value_i,
  output logic            done_o,
  output logic [MagW-1:0] root_o
);
  logic [31:0] rem_q, res_q, bit_q;
  logic        busy_q, done_q;
  logic [31:0] trial;

  assign trial = res_q + bit_q;

  // one result bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rem_q  <= value_i;
        res_q  <= '0;
        bit_q  <= 32'h4000_0000;
      end else if (busy_q) begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[MagW-1:0];
endmodule

FILE: hw/rtl/isd_div.sv
module isd_div #(
  parameter int DW = 40,
  parameter int NW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [NW-1:0] rem_o
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [NW-1:0] rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [NW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = ge ? (trial - {1'b0, dvs_q}) : trial;

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        rem_q <= diff[NW-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule

FILE: hw/rtl/imu_stability_detector.sv
// Steps: square the axes, root both magnitudes, drop the oldest entry when the ring is full,
//   insert into the ring, drop stale entries, divide for mean and variance, root the deviation,
//   then divide for the two part scores, each skipped when that part score is zero.
// Throughput: one sample at a time, taken only in idle; the next sample is taken while the
//   last result still waits in the output register.
// Reset: asynchronous, active low; ring empty, sums and hold tracking cleared, config at defaults.
module imu_stability_detector import isd_pkg::*; #(
  parameter int HISTORY_DEPTH = DefHistoryDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  isd_sample_if.sink        sample_i,
  isd_result_if.source      result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);
  localparam int IdxW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int SumW  = MagW + CntW;
  localparam int SqW   = 2 * MagW + CntW;
  localparam int DivNW = (CntW > CfgW) ? CntW : CfgW;
  localparam int EntW  = TimeW + MagW;
  localparam int TotW  = 2 * ShareW;

  typedef enum logic [22:0] {
    S_IDLE = 23'h000001,
    S_SQR  = 23'h000002,
    S_SQA  = 23'h000004,
    S_SQG  = 23'h000008,
    S_ASQ  = 23'h000010,
    S_INS  = 23'h000020,
    S_RD   = 23'h000040,
    S_CHK  = 23'h000080,
    S_SUB  = 23'h000100,
    S_D1   = 23'h000200,
    S_M1   = 23'h000400,
    S_M2   = 23'h000800,
    S_M3   = 23'h001000,
    S_TT   = 23'h002000,
    S_D2   = 23'h004000,
    S_M4   = 23'h008000,
    S_M5   = 23'h010000,
    S_SQD  = 23'h020000,
    S_PG   = 23'h040000,
    S_PA   = 23'h080000,
    S_W1   = 23'h100000,
    S_W2   = 23'h200000,
    S_OUT  = 23'h400000
  } state_e;

  state_e state_q;

  // configuration
  logic [CfgW-1:0]   gyro_limit_q, accel_limit_q, hold_time_q, window_q;
  logic [ShareW-1:0] gyro_share_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_limit_q  <= RstGyroLimit;
      accel_limit_q <= RstAccelLimit;
      hold_time_q   <= RstHoldTime;
      window_q      <= RstWindow;
      gyro_share_q  <= RstGyroShare;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[4:2]))
        RegGyroLimit:     gyro_limit_q  <= pwdata[CfgW-1:0];
        RegAccelDevLimit: accel_limit_q <= pwdata[CfgW-1:0];
        RegHoldTime:      hold_time_q   <= pwdata[CfgW-1:0];
        RegWindow:        window_q      <= pwdata[CfgW-1:0];
        RegGyroShare:     gyro_share_q  <= pwdata[ShareW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      RegGyroLimit:     prdata = DataW'(gyro_limit_q);
      RegAccelDevLimit: prdata = DataW'(accel_limit_q);
      RegHoldTime:      prdata = DataW'(hold_time_q);
      RegWindow:        prdata = DataW'(window_q);
      RegGyroShare:     prdata = DataW'(gyro_share_q);
      default:          prdata = '0;
    endcase
  end

  // sample and working registers
  logic signed [AxisW-1:0] rx_q, ry_q, rz_q, ax_q, ay_q, az_q;
  logic [TimeW-1:0]        now_q;
  logic [2:0]              k_q;
  logic [2*AxisW-1:0]      prod_q;
  logic [31:0]             sa_q, sg_q;
  logic [MagW-1:0]         amag_q, gmag_q, dev_q, m_q, q_q;
  logic [IdxW-1:0]         head_q;
  logic [CntW-1:0]         count_q, r_q, b_q;
  logic [SumW-1:0]         sum_q;
  logic [SqW-1:0]          sqs_q, pa_q, t_q, a_q;
  logic [SumW-1:0]         pb_q;
  logic [31:0]             var_q;
  logic                    pre_q, sq_run_q, div_run_q;
  logic [ShareW-1:0]       gs_q, as_q;
  logic [TotW-1:0]         tot_q;
  logic                    was_met_q;
  logic [TimeW-1:0]        met_since_q;

  // output register
  logic              ovalid_q;
  logic [MagW-1:0]   o_rot_q, o_dev_q;
  logic [ScoreW-1:0] o_score_q;
  logic [HistW-1:0]  o_count_q;
  logic [TimeW-1:0]  o_held_q;
  logic              o_still_q;

  logic in_xfer;
  assign sample_i.ready = (state_q == S_IDLE);
  assign in_xfer        = sample_i.valid && sample_i.ready;

  // squaring of one axis per cycle
  logic signed [AxisW-1:0]   axis_sel;
  logic signed [2*AxisW-1:0] axis_sq;
  always_comb begin
    unique case (k_q)
      3'd0:    axis_sel = ax_q;
      3'd1:    axis_sel = ay_q;
      3'd2:    axis_sel = az_q;
      3'd3:    axis_sel = rx_q;
      3'd4:    axis_sel = ry_q;
      3'd5:    axis_sel = rz_q;
      default: axis_sel = '0;
    endcase
  end
  assign axis_sq = axis_sel * axis_sel;

  // ring memory: {time, magnitude}
  logic [EntW-1:0] rd_ent;
  logic [TimeW-1:0] rd_time, age;
  logic [MagW-1:0]  rd_mag;
  logic [CntW:0]    slot_sum, slot_wrap;
  logic [IdxW-1:0]  slot, head_nx;

  assign slot_sum  = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign slot_wrap = (slot_sum >= (CntW+1)'(HISTORY_DEPTH)) ?
                     slot_sum - (CntW+1)'(HISTORY_DEPTH) : slot_sum;
  assign slot      = slot_wrap[IdxW-1:0];
  assign head_nx   = (head_q == IdxW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign rd_time   = rd_ent[EntW-1:MagW];
  assign rd_mag    = rd_ent[MagW-1:0];
  assign age       = now_q - rd_time;

  // the write in S_INS lands before the read in S_RD, so no bypass is needed
  isd_ram #(.Width(EntW), .Depth(HISTORY_DEPTH)) u_isd_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == S_INS),
    .waddr_i (slot),
    .wdata_i ({now_q, amag_q}),
    .re_i    (state_q == S_RD),
    .raddr_i (head_q),
    .rdata_o (rd_ent)
  );

  // shared root unit
  logic            sq_start, sq_done;
  logic [31:0]     sq_in;
  logic [MagW-1:0] sq_res;

  always_comb begin
    priority case (1'b1)
      state_q == S_SQA: sq_in = sa_q;
      state_q == S_SQG: sq_in = sg_q;
      default:          sq_in = var_q;
    endcase
  end
  assign sq_start = !sq_run_q &&
                    (state_q == S_SQA || state_q == S_SQG || state_q == S_SQD);

  isd_sqrt u_isd_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_in),
    .done_o  (sq_done),
    .root_o  (sq_res)
  );

  // shared divider
  logic             need_g, need_a, div_start, div_done;
  logic [SqW-1:0]   div_a;
  logic [DivNW-1:0] div_b;
  logic [SqW-1:0]   div_q;
  logic [DivNW-1:0] div_r;
  logic [MagW-1:0]  g_gap, a_gap;

  assign need_g = (gyro_limit_q != '0) && (gmag_q < gyro_limit_q);
  assign need_a = (accel_limit_q != '0) && (dev_q < accel_limit_q);
  assign g_gap  = gyro_limit_q - gmag_q;
  assign a_gap  = accel_limit_q - dev_q;

  always_comb begin
    priority case (1'b1)
      state_q == S_D1: begin
        div_a = SqW'(sum_q);
        div_b = DivNW'(count_q);
      end
      state_q == S_D2: begin
        div_a = t_q;
        div_b = DivNW'(count_q);
      end
      state_q == S_PG: begin
        div_a = SqW'({g_gap, 16'h0000});
        div_b = DivNW'(gyro_limit_q);
      end
      default: begin
        div_a = SqW'({a_gap, 16'h0000});
        div_b = DivNW'(accel_limit_q);
      end
    endcase
  end
  assign div_start = !div_run_q && (state_q == S_D1 || state_q == S_D2 ||
                     (state_q == S_PG && need_g) || (state_q == S_PA && need_a));

  isd_div #(.DW(SqW), .NW(DivNW)) u_isd_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // criteria
  logic [AxisW:0]    abs_x, abs_y, abs_z;
  logic              met;
  logic [ShareW-1:0] gw;
  logic [TimeW-1:0]  held;

  assign abs_x = rx_q[AxisW-1] ? -{rx_q[AxisW-1], rx_q} : {1'b0, rx_q};
  assign abs_y = ry_q[AxisW-1] ? -{ry_q[AxisW-1], ry_q} : {1'b0, ry_q};
  assign abs_z = rz_q[AxisW-1] ? -{rz_q[AxisW-1], rz_q} : {1'b0, rz_q};
  assign met   = (gmag_q < gyro_limit_q) && (dev_q < accel_limit_q) &&
                 (abs_x < {1'b0, gyro_limit_q}) && (abs_y < {1'b0, gyro_limit_q}) &&
                 (abs_z < {1'b0, gyro_limit_q});
  assign gw    = (gyro_share_q > FullShare) ? FullShare : gyro_share_q;
  assign held  = was_met_q ? (now_q - met_since_q) : '0;

  logic [2*CntW-1:0] rr;
  assign rr = (2*CntW)'(r_q) * (2*CntW)'(r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      head_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      sqs_q       <= '0;
      pre_q       <= 1'b0;
      sq_run_q    <= 1'b0;
      div_run_q   <= 1'b0;
      was_met_q   <= 1'b0;
      met_since_q <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (sq_start)  sq_run_q  <= 1'b1;
      if (sq_done)   sq_run_q  <= 1'b0;
      if (div_start) div_run_q <= 1'b1;
      if (div_done)  div_run_q <= 1'b0;
      if (result_o.valid && result_o.ready) ovalid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            rx_q    <= sample_i.rot_x;
            ry_q    <= sample_i.rot_y;
            rz_q    <= sample_i.rot_z;
            ax_q    <= sample_i.acc_x;
            ay_q    <= sample_i.acc_y;
            az_q    <= sample_i.acc_z;
            now_q   <= sample_i.time_ms;
            k_q     <= '0;
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          prod_q <= axis_sq;
          if (k_q == 3'd0) begin
            sa_q <= '0;
            sg_q <= '0;
          end else if (k_q <= 3'd3) begin
            sa_q <= sa_q + prod_q;
          end else begin
            sg_q <= sg_q + prod_q;
          end
          k_q <= k_q + 1'b1;
          if (k_q == 3'd6) state_q <= S_SQA;
        end
        S_SQA: begin
          if (sq_done) begin
            amag_q  <= sq_res;
            state_q <= S_SQG;
          end
        end
        S_SQG: begin
          if (sq_done) begin
            gmag_q <= sq_res;
            if (count_q == CntW'(HISTORY_DEPTH)) begin
              pre_q   <= 1'b1;
              state_q <= S_RD;
            end else begin
              state_q <= S_ASQ;
            end
          end
        end
        S_ASQ: begin
          prod_q  <= amag_q * amag_q;
          state_q <= S_INS;
        end
        S_INS: begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_q + SumW'(amag_q);
          sqs_q   <= sqs_q + SqW'(prod_q);
          pre_q   <= 1'b0;
          state_q <= S_RD;
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          // drop when the ring is full, else when the oldest entry is too old
          if (pre_q || age > TimeW'(window_q)) begin
            m_q     <= rd_mag;
            prod_q  <= rd_mag * rd_mag;
            state_q <= S_SUB;
          end else begin
            state_q <= S_D1;
          end
        end
        S_SUB: begin
          sum_q   <= sum_q - SumW'(m_q);
          sqs_q   <= sqs_q - SqW'(prod_q);
          head_q  <= head_nx;
          count_q <= count_q - 1'b1;
          state_q <= pre_q ? S_ASQ : S_RD;
        end
        S_D1: begin
          if (div_done) begin
            q_q     <= div_q[MagW-1:0];
            r_q     <= div_r[CntW-1:0];
            state_q <= S_M1;
          end
        end
        S_M1: begin
          pa_q    <= SqW'(32'(q_q) * 32'(q_q));
          state_q <= S_M2;
        end
        S_M2: begin
          pa_q    <= SqW'(count_q) * SqW'(pa_q[2*MagW-1:0]);
          state_q <= S_M3;
        end
        S_M3: begin
          pb_q    <= q_q * r_q;
          state_q <= S_TT;
        end
        S_TT: begin
          t_q     <= sqs_q - pa_q - SqW'({pb_q, 1'b0});
          state_q <= S_D2;
        end
        S_D2: begin
          if (div_done) begin
            a_q     <= div_q;
            b_q     <= div_r[CntW-1:0];
            state_q <= S_M4;
          end
        end
        S_M4: begin
          pa_q    <= SqW'((2*CntW)'(b_q) * (2*CntW)'(count_q));
          state_q <= S_M5;
        end
        S_M5: begin
          // step down by one when the dropped remainder term pulls below
          if (pa_q < SqW'(rr) && a_q != '0) begin
            var_q <= 32'(a_q - 1'b1);
          end else begin
            var_q <= 32'(a_q);
          end
          state_q <= S_SQD;
        end
        S_SQD: begin
          if (sq_done) begin
            dev_q   <= sq_res;
            state_q <= S_PG;
          end
        end
        S_PG: begin
          if (!need_g) begin
            gs_q    <= '0;
            state_q <= S_PA;
          end else if (div_done) begin
            gs_q    <= div_q[ShareW-1:0];
            state_q <= S_PA;
          end
        end
        S_PA: begin
          if (!need_a) begin
            as_q    <= '0;
            state_q <= S_W1;
          end else if (div_done) begin
            as_q    <= div_q[ShareW-1:0];
            state_q <= S_W1;
          end
        end
        S_W1: begin
          tot_q   <= gs_q * gw;
          state_q <= S_W2;
        end
        S_W2: begin
          tot_q   <= tot_q + as_q * (FullShare - gw);
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the previous result has been taken
          if (!ovalid_q) begin
            ovalid_q  <= 1'b1;
            o_rot_q   <= gmag_q;
            o_dev_q   <= dev_q;
            o_score_q <= tot_q[ScoreW+15:16];
            o_count_q <= HistW'(count_q);
            if (met) begin
              if (!was_met_q) begin
                was_met_q   <= 1'b1;
                met_since_q <= now_q;
              end
              o_held_q  <= held;
              o_still_q <= held >= TimeW'(hold_time_q);
            end else begin
              was_met_q <= 1'b0;
              o_held_q  <= '0;
              o_still_q <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid         = ovalid_q;
  assign result_o.rot_magnitude = o_rot_q;
  assign result_o.acc_deviation = o_dev_q;
  assign result_o.score         = o_score_q;
  assign result_o.history_count = o_count_q;
  assign result_o.held_ms       = o_held_q;
  assign result_o.still         = o_still_q;
endmodule

FILE: hw/rtl/isd_checker.sv
module isd_checker import isd_pkg::*; #(
  parameter int HISTORY_DEPTH = DefHistoryDepth
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ScoreW-1:0] out_score,
  input logic [HistW-1:0]  out_count,
  input logic [TimeW-1:0]  out_held,
  input logic              out_still
);
  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_held)
      && $stable(out_still) && $stable(out_score))
    else $error("result changed while stalled");

  // one sample in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_score <= FullShare)
    else $error("score above full scale");

  // the newest entry always stays in the window
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (HISTORY_DEPTH > 511) || (out_count != '0))
    else $error("empty history reported");
endmodule

bind imu_stability_detector isd_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_isd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_score (result_o.score),
  .out_count (result_o.history_count),
  .out_held  (result_o.held_ms),
  .out_still (result_o.still)
);

FILE: verif/imu_stability_detector_test.sv
module imu_stability_detector_test import isd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RingDepth = DefHistoryDepth;
  localparam int CycleLimit = 6000000;
  localparam int SettleCycles = 800;

  typedef struct {
    logic signed [AxisW-1:0] rot_x, rot_y, rot_z;
    logic signed [AxisW-1:0] acc_x, acc_y, acc_z;
    logic [TimeW-1:0]        time_ms;
  } imu_sample_t;

  typedef struct {
    logic [MagW-1:0]   rot_magnitude;
    logic [MagW-1:0]   acc_deviation;
    logic [ScoreW-1:0] score;
    logic [HistW-1:0]  history_count;
    logic [TimeW-1:0]  held_ms;
    logic              still;
  } stillness_result_t;

  class stillness_scoreboard;
    logic [CfgW-1:0]   gyro_limit, accel_dev_limit, hold_time, window;
    logic [ShareW-1:0] gyro_share;
    logic [16:0]       mag_ring[RingDepth];
    logic [31:0]       time_ring[RingDepth];
    int unsigned       ring_head, ring_count;
    longint unsigned   mag_sum, mag_square_sum;
    bit                was_met;
    logic [31:0]       met_since;
    stillness_result_t expected_results[$];
    int unsigned       errors, samples, results, still_seen, full_ring_seen;

    function new();
      gyro_limit = RstGyroLimit;
      accel_dev_limit = RstAccelLimit;
      hold_time = RstHoldTime;
      window = RstWindow;
      gyro_share = RstGyroShare;
      ring_head = 0;
      ring_count = 0;
      mag_sum = 0;
      mag_square_sum = 0;
      was_met = 0;
      met_since = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        RegGyroLimit:     gyro_limit = value[CfgW-1:0];
        RegAccelDevLimit: accel_dev_limit = value[CfgW-1:0];
        RegHoldTime:      hold_time = value[CfgW-1:0];
        RegWindow:        window = value[CfgW-1:0];
        RegGyroShare:     gyro_share = value[ShareW-1:0];
        default: ;
      endcase
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic longint unsigned vec_magnitude(longint a, longint b, longint c);
      return root64(longint'(unsigned'(a * a)) + (b * b) + (c * c));
    endfunction

    function automatic longint unsigned part_score(longint unsigned value,
                                                    longint unsigned limit);
      if (limit == 0 || value >= limit) return 0;
      return (64'd65536 * (limit - value)) / limit;
    endfunction

    function void drop_oldest();
      longint unsigned m = mag_ring[ring_head];
      mag_sum -= m;
      mag_square_sum -= m * m;
      ring_head = (ring_head + 1) % RingDepth;
      ring_count--;
    endfunction

    function automatic longint unsigned floor_variance();
      longint unsigned n = ring_count;
      longint unsigned q, r, t, a, b;
      if (n == 0) return 0;
      q = mag_sum / n;
      r = mag_sum % n;
      t = mag_square_sum - n * q * q - 2 * q * r;
      a = t / n;
      b = t % n;
      if (b * n < r * r) return (a == 0) ? 0 : a - 1;
      return a;
    endfunction

    // Work out the result of one accepted sample and queue it.
    function void note_sample(imu_sample_t s);
      longint rx = s.rot_x, ry = s.rot_y, rz = s.rot_z;
      longint unsigned amag, gmag, dev, gw, total, slot;
      logic [31:0] now = s.time_ms;
      logic [31:0] held = 0;
      bit met;
      bit is_still = 0;
      stillness_result_t exp_res;
      amag = vec_magnitude(s.acc_x, s.acc_y, s.acc_z);
      gmag = vec_magnitude(rx, ry, rz);
      if (ring_count >= RingDepth) begin
        drop_oldest();
        full_ring_seen++;
      end
      slot = (ring_head + ring_count) % RingDepth;
      mag_ring[slot] = amag[16:0];
      time_ring[slot] = now;
      ring_count++;
      mag_sum += amag;
      mag_square_sum += amag * amag;
      while (ring_count > 0 && (32'(now - time_ring[ring_head]) > window)) drop_oldest();
      dev = root64(floor_variance());
      gw = (gyro_share > FullShare) ? 64'd65536 : gyro_share;
      total = part_score(gmag, gyro_limit) * gw +
              part_score(dev, accel_dev_limit) * (64'd65536 - gw);
      met = gmag < gyro_limit && dev < accel_dev_limit &&
            (rx < 0 ? -rx : rx) < gyro_limit && (ry < 0 ? -ry : ry) < gyro_limit &&
            (rz < 0 ? -rz : rz) < gyro_limit;
      if (met) begin
        if (!was_met) begin
          met_since = now;
          was_met = 1;
        end
        held = now - met_since;
        is_still = held >= hold_time;
      end else begin
        was_met = 0;
      end
      exp_res.rot_magnitude = (gmag > 64'hFFFF) ? 16'hFFFF : gmag[15:0];
      exp_res.acc_deviation = (dev > 64'hFFFF) ? 16'hFFFF : dev[15:0];
      exp_res.score = total[32:16];
      exp_res.history_count = ring_count[8:0];
      exp_res.held_ms = held;
      exp_res.still = is_still;
      expected_results = {expected_results, exp_res};
      samples++;
    endfunction

    function void compare_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(stillness_result_t got);
      stillness_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, got magnitude %0d score %0d",
                 $time, got.rot_magnitude, got.score);
        errors++;
        return;
      end
      e = expected_results[0];
      expected_results.delete(0);
      results++;
      if (got.still === 1'b1) still_seen++;
      compare_field("rot_magnitude", e.rot_magnitude, got.rot_magnitude);
      compare_field("acc_deviation", e.acc_deviation, got.acc_deviation);
      compare_field("score", e.score, got.score);
      compare_field("history_count", e.history_count, got.history_count);
      compare_field("held_ms", e.held_ms, got.held_ms);
      if (got.still !== e.still) begin
        $display("%0t: still expected %0b, got %0b", $time, e.still, got.still);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  logic pready;
  bit quiet = 0;
  int unsigned cycles = 0;
  logic [31:0] now_ms = 0;
  int unsigned max_step = 20;

  isd_sample_if sample_if ();
  isd_result_if result_if ();

  stillness_scoreboard sb = new();

  imu_stability_detector DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .result_o (result_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    result_if.ready <= quiet || ($urandom_range(99) >= 28);
  end

  always @(posedge clk_i) begin
    stillness_result_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.rot_magnitude = result_if.rot_magnitude;
      got.acc_deviation = result_if.acc_deviation;
      got.score = result_if.score;
      got.history_count = result_if.history_count;
      got.held_ms = result_if.held_ms;
      got.still = result_if.still;
      sb.check_result(got);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic push_sample(imu_sample_t s);
    while (!quiet && $urandom_range(99) < 28) begin
      sample_if.valid <= 0;
      @(negedge clk_i);
    end
    sample_if.rot_x <= s.rot_x;
    sample_if.rot_y <= s.rot_y;
    sample_if.rot_z <= s.rot_z;
    sample_if.acc_x <= s.acc_x;
    sample_if.acc_y <= s.acc_y;
    sample_if.acc_z <= s.acc_z;
    sample_if.time_ms <= s.time_ms;
    sample_if.valid <= 1;
    do @(posedge clk_i); while (!sample_if.ready);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  // Hold until every queued result has been taken, then let the block go idle.
  task automatic drain();
    sample_if.valid <= 0;
    @(negedge clk_i);
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic setup(logic [31:0] g, logic [31:0] a, logic [31:0] h,
                       logic [31:0] w, logic [31:0] s, int unsigned step);
    drain();
    write_reg(RegGyroLimit, g);
    write_reg(RegAccelDevLimit, a);
    write_reg(RegHoldTime, h);
    write_reg(RegWindow, w);
    write_reg(RegGyroShare, s);
    max_step = step;
  endtask

  function automatic imu_sample_t mk(int rx, int ry, int rz, int ax, int ay, int az,
                                     logic [31:0] t);
    imu_sample_t s;
    s.rot_x = AxisW'(rx); s.rot_y = AxisW'(ry); s.rot_z = AxisW'(rz);
    s.acc_x = AxisW'(ax); s.acc_y = AxisW'(ay); s.acc_z = AxisW'(az);
    s.time_ms = t;
    return s;
  endfunction

  function automatic int around(int center, int spread);
    int v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int cap(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  // Mostly still or moving runs with steady time; the rest is raw noise and time jumps.
  task automatic random_run(int unsigned count);
    imu_sample_t s;
    int unsigned mode, left, r;
    int gk, ak, base_x, base_y, base_z;
    left = 0;
    mode = 0;
    base_x = 0; base_y = 0; base_z = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(10, 60);
        mode = $urandom_range(0, 9);
        base_x = around(0, 20000);
        base_y = around(0, 20000);
        base_z = around(0, 20000);
      end
      left--;
      r = $urandom_range(99);
      if (r < 3) now_ms = now_ms - $urandom_range(1, sb.window + 50);
      else if (r < 5) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, max_step);
      gk = cap(sb.gyro_limit / 3, 32767);
      ak = cap(sb.accel_dev_limit / 3, 32767);
      if (mode < 6) begin
        s = mk(around(0, gk), around(0, gk), around(0, gk),
               around(base_x, ak), around(base_y, ak), around(base_z, ak), now_ms);
      end else if (mode < 8) begin
        s = mk(around(0, cap(sb.gyro_limit * 2, 32767)), around(0, gk), around(0, gk),
               around(base_x, 8000), around(base_y, 8000), around(base_z, 8000), now_ms);
      end else begin
        s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, now_ms);
      end
      push_sample(s);
      if (i == count / 2 && mode == 0) drain();
    end
  endtask

  initial begin
    sample_if.valid = 0;
    sample_if.rot_x = 0; sample_if.rot_y = 0; sample_if.rot_z = 0;
    sample_if.acc_x = 0; sample_if.acc_y = 0; sample_if.acc_z = 0;
    sample_if.time_ms = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: extremes, thresholds, hold, time wrap and time going backwards.
    push_sample(mk(0, 0, 0, 0, 0, 0, 0));
    push_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, 1));
    push_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 2));
    push_sample(mk(-32768, 32767, 0, 32767, -32768, 0, 3));
    push_sample(mk(100, 0, 0, 0, 0, 16384, 2000));
    push_sample(mk(99, 0, 0, 0, 0, 16384, 2001));
    push_sample(mk(0, -100, 0, 0, 0, 16384, 2002));
    push_sample(mk(57, 57, 57, 0, 0, 16384, 2003));
    for (int k = 0; k <= 7; k++) push_sample(mk(1, -1, 0, 0, 10, 16380, 3000 + 100 * k));
    push_sample(mk(1, 1, 1, 0, 0, 16384, 1500));
    push_sample(mk(1, 1, 1, 0, 0, 16384, 32'hFFFF_FFF0));
    push_sample(mk(1, 1, 1, 0, 0, 16384, 32'h0000_0010));
    push_sample(mk(0, 0, 0, 5000, -5000, 0, 32'h0000_0020));
    now_ms = 32'h0000_0100;

    setup(0, 0, 100, 50, 17'h1FFFF, 5);
    for (int k = 0; k < 4; k++) push_sample(mk(0, 0, 0, 0, 0, 100 * k, 400 + k));
    random_run(196);
    setup(65535, 65535, 0, 65535, FullShare, 2);
    quiet = 1;
    random_run(300);
    quiet = 0;
    random_run(100);
    setup(1, 1, 65535, 0, 0, 3);
    random_run(200);
    setup(RstGyroLimit, RstAccelLimit, RstHoldTime, RstWindow, RstGyroShare, 20);
    random_run(250);
    repeat (3) begin
      setup($urandom_range(50, 3000), $urandom_range(50, 3000), $urandom_range(0, 800),
            $urandom_range(100, 3000), $urandom_range(0, 65536), 10);
      random_run(230);
    end

    drain();
    $display("Covered %0d samples and %0d results, %0d still reports, %0d full-ring drops",
             sb.samples, sb.results, sb.still_seen, sb.full_ring_seen);
    $display("Register settings spanned limits of 0 to 65535, zero and full windows and shares");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
